// ===== rtl/lrupr_pkg.sv =====
// Package for the LRU page replacement block.
// Holds the sequencer state type and the fixed field widths and constants.
// No dependencies.
`default_nettype none

package lrupr_pkg;

  // Field widths fixed by the interface.
  localparam int PAGE_W      = 16;
  localparam int PAGE_BITS   = 16;
  localparam int STAMP_W     = 32;
  localparam int CFG_W       = 5;
  localparam int FRAME_OUT_W = 4;

  // Page numbers are kept to PAGE_BITS bits.
  localparam logic [PAGE_W-1:0] PAGE_MASK = PAGE_W'((33'h1 << PAGE_BITS) - 33'h1);

  // Saturation value of the stamp and fault counters.
  localparam logic [STAMP_W-1:0] WORD_MAX = {STAMP_W{1'b1}};

  // Frame count after reset.
  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(16);

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement: one page access per beat, one result beat per access.
// No new access is taken until the last result is in the output register. The
// sequencer walks the single read port of the frame tables, one frame per cycle.
// Reset clears the valid marks, stamp and fault counters; frame count is 16.
// Depends on lrupr_pkg and lrupr_ram.
`default_nettype none

module lru_page_replacement #(
  parameter int MAX_FRAMES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write.
  input  wire logic                          cfg_wr_en,
  input  wire logic [lrupr_pkg::CFG_W-1:0]   cfg_wr_data,
  // Input channel.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lrupr_pkg::PAGE_W-1:0]  page_number,
  input  wire logic                          last_access,
  // Output channel.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               hit,
  output logic [lrupr_pkg::FRAME_OUT_W-1:0]  frame_used,
  output logic                               evicted_valid,
  output logic [lrupr_pkg::PAGE_W-1:0]       evicted_page,
  output logic [lrupr_pkg::STAMP_W-1:0]      fault_count
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);

  lrupr_pkg::state_t state, state_next;

  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use;
  logic [MAX_FRAMES-1:0]         frame_valid, frame_valid_next;
  logic [lrupr_pkg::STAMP_W-1:0] access_index, access_index_next;
  logic [lrupr_pkg::STAMP_W-1:0] fault_total, fault_total_next;

  // Current access.
  logic [lrupr_pkg::PAGE_W-1:0] cur_page, cur_page_next;
  logic                         cur_last, cur_last_next;

  // Scan pointer and the compare stage that trails it by one register.
  logic [CNT_W-1:0] issue_cnt, issue_cnt_next;
  logic             chk_v, chk_v_next;
  logic [IDX_W-1:0] chk_idx, chk_idx_next;

  // Search results.
  logic                          found, found_next;
  logic [IDX_W-1:0]              hit_idx, hit_idx_next;
  logic                          empty_found, empty_found_next;
  logic [IDX_W-1:0]              empty_idx, empty_idx_next;
  logic [lrupr_pkg::STAMP_W-1:0] old_stamp, old_stamp_next;
  logic [IDX_W-1:0]              old_idx, old_idx_next;
  logic [lrupr_pkg::PAGE_W-1:0]  old_page, old_page_next;

  // Output register.
  logic                          out_valid_next;
  logic                          hit_next;
  logic [lrupr_pkg::FRAME_OUT_W-1:0] frame_used_next;
  logic                          evicted_valid_next;
  logic [lrupr_pkg::PAGE_W-1:0]  evicted_page_next;
  logic [lrupr_pkg::STAMP_W-1:0] fault_count_next;

  // Table ports.
  logic                          page_we, stamp_we;
  logic [IDX_W-1:0]              wr_idx;
  logic [lrupr_pkg::PAGE_W-1:0]  page_rd;
  logic [lrupr_pkg::STAMP_W-1:0] stamp_rd;

  // Active frame count: zero counts as one, large values clip to the table size.
  logic [CNT_W-1:0] n_active;
  always_comb begin
    if (frames_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(MAX_FRAMES)) begin
      n_active = CNT_W'(MAX_FRAMES);
    end else begin
      n_active = CNT_W'(frames_in_use);
    end
  end

  lrupr_ram #(
    .WIDTH (lrupr_pkg::PAGE_W),
    .DEPTH (MAX_FRAMES)
  ) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (wr_idx),
    .wdata (cur_page),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (page_rd)
  );

  lrupr_ram #(
    .WIDTH (lrupr_pkg::STAMP_W),
    .DEPTH (MAX_FRAMES)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (wr_idx),
    .wdata (access_index),
    .raddr (issue_cnt[IDX_W-1:0]),
    .rdata (stamp_rd)
  );

  assign in_stall = (state != lrupr_pkg::ST_IDLE);

  // Sequencer: next state, search updates and the table update.
  always_comb begin
    logic out_free;
    logic is_first;
    state_next         = state;
    frame_valid_next   = frame_valid;
    access_index_next  = access_index;
    fault_total_next   = fault_total;
    cur_page_next      = cur_page;
    cur_last_next      = cur_last;
    issue_cnt_next     = issue_cnt;
    chk_v_next         = 1'b0;
    chk_idx_next       = chk_idx;
    found_next         = found;
    hit_idx_next       = hit_idx;
    empty_found_next   = empty_found;
    empty_idx_next     = empty_idx;
    old_stamp_next     = old_stamp;
    old_idx_next       = old_idx;
    old_page_next      = old_page;
    out_valid_next     = out_valid && out_stall;
    hit_next           = hit;
    frame_used_next    = frame_used;
    evicted_valid_next = evicted_valid;
    evicted_page_next  = evicted_page;
    fault_count_next   = fault_count;
    page_we            = 1'b0;
    stamp_we           = 1'b0;
    wr_idx             = hit_idx;
    out_free           = !out_valid || !out_stall;
    is_first           = (chk_idx == '0);

    // Compare stage: one frame's read data per cycle.
    if (chk_v) begin
      if (frame_valid[chk_idx] && (page_rd == cur_page) && !found) begin
        found_next   = 1'b1;
        hit_idx_next = chk_idx;
      end
      if (!frame_valid[chk_idx] && !empty_found) begin
        empty_found_next = 1'b1;
        empty_idx_next   = chk_idx;
      end
      if (is_first || (stamp_rd < old_stamp)) begin
        old_stamp_next = stamp_rd;
        old_idx_next   = chk_idx;
        old_page_next  = page_rd;
      end
    end

    unique case (state)
      lrupr_pkg::ST_IDLE: begin
        if (in_valid) begin
          cur_page_next    = page_number & lrupr_pkg::PAGE_MASK;
          cur_last_next    = last_access;
          issue_cnt_next   = '0;
          found_next       = 1'b0;
          empty_found_next = 1'b0;
          state_next       = lrupr_pkg::ST_SCAN;
        end
      end

      lrupr_pkg::ST_SCAN: begin
        if (issue_cnt != n_active) begin
          chk_v_next     = 1'b1;
          chk_idx_next   = issue_cnt[IDX_W-1:0];
          issue_cnt_next = issue_cnt + CNT_W'(1);
        end else begin
          // The last frame is being compared in this cycle.
          state_next = lrupr_pkg::ST_UPDATE;
        end
      end

      lrupr_pkg::ST_UPDATE: begin
        if (out_free) begin
          logic [lrupr_pkg::STAMP_W-1:0] faults;
          logic [IDX_W-1:0]              used;
          logic                          evict;
          faults = fault_total;
          used   = hit_idx;
          evict  = 1'b0;
          stamp_we = 1'b1;
          if (!found) begin
            if (fault_total != lrupr_pkg::WORD_MAX) begin
              faults = fault_total + lrupr_pkg::STAMP_W'(1);
            end
            page_we = 1'b1;
            if (empty_found) begin
              used = empty_idx;
            end else begin
              used  = old_idx;
              evict = 1'b1;
            end
          end
          wr_idx = used;

          hit_next           = found;
          frame_used_next    = lrupr_pkg::FRAME_OUT_W'(used);
          evicted_valid_next = evict;
          evicted_page_next  = evict ? old_page : '0;
          fault_count_next   = faults;
          out_valid_next     = 1'b1;

          // End of a sequence clears the table and both counters.
          if (cur_last) begin
            frame_valid_next  = '0;
            access_index_next = '0;
            fault_total_next  = '0;
          end else begin
            frame_valid_next[used] = 1'b1;
            fault_total_next       = faults;
            if (access_index != lrupr_pkg::WORD_MAX) begin
              access_index_next = access_index + lrupr_pkg::STAMP_W'(1);
            end
          end
          state_next = lrupr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lrupr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state resets; payload registers just load.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lrupr_pkg::ST_IDLE;
      frames_in_use <= lrupr_pkg::FRAMES_RESET;
      frame_valid   <= '0;
      access_index  <= '0;
      fault_total   <= '0;
      chk_v         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state        <= state_next;
      frame_valid  <= frame_valid_next;
      access_index <= access_index_next;
      fault_total  <= fault_total_next;
      chk_v        <= chk_v_next;
      out_valid    <= out_valid_next;
      if (cfg_wr_en) begin
        frames_in_use <= cfg_wr_data;
      end
    end
    cur_page      <= cur_page_next;
    cur_last      <= cur_last_next;
    issue_cnt     <= issue_cnt_next;
    chk_idx       <= chk_idx_next;
    found         <= found_next;
    hit_idx       <= hit_idx_next;
    empty_found   <= empty_found_next;
    empty_idx     <= empty_idx_next;
    old_stamp     <= old_stamp_next;
    old_idx       <= old_idx_next;
    old_page      <= old_page_next;
    hit           <= hit_next;
    frame_used    <= frame_used_next;
    evicted_valid <= evicted_valid_next;
    evicted_page  <= evicted_page_next;
    fault_count   <= fault_count_next;
  end

endmodule

`default_nettype wire

// ===== rtl/lrupr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the frame page and frame stamp tables. No dependencies.
`default_nettype none

module lrupr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== verif/lrupr_checker.sv =====
// Scoreboard for the LRU page replacement block: watches both channels and the config port.
// Keeps its own copy of the frame table, predicts every result beat and checks each field.
// Depends on lrupr_pkg.
`timescale 1ns / 100ps

module lrupr_checker #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lrupr_pkg::CFG_W-1:0]         cfg_wr_data,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [lrupr_pkg::PAGE_W-1:0]        page_number,
  input  logic                                last_access,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic                                hit,
  input  logic [lrupr_pkg::FRAME_OUT_W-1:0]   frame_used,
  input  logic                                evicted_valid,
  input  logic [lrupr_pkg::PAGE_W-1:0]        evicted_page,
  input  logic [lrupr_pkg::STAMP_W-1:0]       fault_count,
  output int                                  errors,
  output int                                  pending
);

  typedef struct packed {
    logic                              hit;
    logic [lrupr_pkg::FRAME_OUT_W-1:0] frame;
    logic                              ev_valid;
    logic [lrupr_pkg::PAGE_W-1:0]      ev_page;
    logic [lrupr_pkg::STAMP_W-1:0]     faults;
  } access_result_t;

  // Shadow copy of the frame table and the sequence counters.
  logic [lrupr_pkg::PAGE_W-1:0]  page_tab [MAX_FRAMES];
  logic                          resident [MAX_FRAMES];
  logic [lrupr_pkg::STAMP_W-1:0] last_use [MAX_FRAMES];
  logic [lrupr_pkg::STAMP_W-1:0] use_clock;
  logic [lrupr_pkg::STAMP_W-1:0] fault_tally;
  logic [lrupr_pkg::CFG_W-1:0]   frame_limit;

  access_result_t expected_results [$];

  function automatic void clear_table();
    for (int f = 0; f < MAX_FRAMES; f++) begin
      page_tab[f] = '0;
      resident[f] = 1'b0;
      last_use[f] = '0;
    end
    use_clock   = '0;
    fault_tally = '0;
  endfunction

  // One access: hit search, then empty-frame fill or oldest-stamp replacement.
  function automatic access_result_t lru_lookup(
    input logic [lrupr_pkg::PAGE_W-1:0] page_in,
    input logic                         seq_end
  );
    access_result_t                r;
    logic [lrupr_pkg::PAGE_W-1:0]  page;
    int unsigned                   span;
    int unsigned                   pick;
    logic                          found;
    logic                          spare;
    logic [lrupr_pkg::STAMP_W-1:0] oldest;
    page  = page_in & lrupr_pkg::PAGE_MASK;
    span  = (frame_limit == 0) ? 1 :
            ((frame_limit > MAX_FRAMES) ? MAX_FRAMES : int'(frame_limit));
    r     = '0;
    found = 1'b0;
    spare = 1'b0;
    pick  = 0;
    for (int unsigned s = 0; s < span; s++) begin
      if (!found && resident[s] && page_tab[s] == page) begin
        found = 1'b1;
        pick  = s;
      end
    end
    if (found) begin
      last_use[pick] = use_clock;
    end else begin
      if (fault_tally != lrupr_pkg::WORD_MAX) fault_tally++;
      for (int unsigned s = 0; s < span; s++) begin
        if (!spare && !resident[s]) begin
          spare = 1'b1;
          pick  = s;
        end
      end
      // No empty frame: the lowest-numbered frame with the smallest stamp goes.
      if (!spare) begin
        oldest = last_use[0];
        pick   = 0;
        for (int unsigned s = 1; s < span; s++) begin
          if (last_use[s] < oldest) begin
            oldest = last_use[s];
            pick   = s;
          end
        end
        r.ev_valid = 1'b1;
        r.ev_page  = page_tab[pick];
      end
      page_tab[pick] = page;
      resident[pick] = 1'b1;
      last_use[pick] = use_clock;
    end
    if (use_clock != lrupr_pkg::WORD_MAX) use_clock++;
    r.hit    = found;
    r.frame  = lrupr_pkg::FRAME_OUT_W'(pick);
    r.faults = fault_tally;
    if (seq_end) clear_table();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
  endtask

  // Result beats are checked before the input beat of the same edge is predicted.
  always @(posedge clk) begin
    access_result_t want;
    if (rst) begin
      frame_limit = lrupr_pkg::FRAMES_RESET;
      clear_table();
      expected_results.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en) frame_limit = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", 0, 0);
        end else begin
          want = expected_results.pop_front();
          if (hit !== want.hit) report_mismatch("hit", 32'(hit), 32'(want.hit));
          if (frame_used !== want.frame)
            report_mismatch("frame_used", 32'(frame_used), 32'(want.frame));
          if (evicted_valid !== want.ev_valid)
            report_mismatch("evicted_valid", 32'(evicted_valid), 32'(want.ev_valid));
          if (evicted_page !== want.ev_page)
            report_mismatch("evicted_page", 32'(evicted_page), 32'(want.ev_page));
          if (fault_count !== want.faults)
            report_mismatch("fault_count", fault_count, want.faults);
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(lru_lookup(page_number, last_access));
    end
    pending = expected_results.size();
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the LRU page replacement testbench: clock, reset, stimulus and the verdict.
// Drives directed and random page accesses under several frame counts and idle patterns.
// Depends on lrupr_pkg, lru_page_replacement and lrupr_checker.
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_FRAMES    = 16;
  localparam int PHASE_ITEMS   = 145;
  localparam int NUM_PHASES    = 12;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_RECV_LIGHT,
    IDLE_NONE
  } idle_mode_t;

  logic                              clk           = 1'b0;
  logic                              rst           = 1'b1;
  logic                              cfg_wr_en     = 1'b0;
  logic [lrupr_pkg::CFG_W-1:0]       cfg_wr_data   = '0;
  logic                              in_valid      = 1'b0;
  logic                              in_stall;
  logic [lrupr_pkg::PAGE_W-1:0]      page_number   = '0;
  logic                              last_access   = 1'b0;
  logic                              out_valid;
  logic                              out_stall     = 1'b0;
  logic                              hit;
  logic [lrupr_pkg::FRAME_OUT_W-1:0] frame_used;
  logic                              evicted_valid;
  logic [lrupr_pkg::PAGE_W-1:0]      evicted_page;
  logic [lrupr_pkg::STAMP_W-1:0]     fault_count;

  int error_total;
  int pending_results;
  int accesses_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Frame counts per random phase; zero and values past the maximum are included.
  logic [lrupr_pkg::CFG_W-1:0] frame_plan [NUM_PHASES] =
    '{5'd16, 5'd1, 5'd2, 5'd4, 5'd8, 5'd17, 5'd31, 5'd0, 5'd5, 5'd12, 5'd3, 5'd15};

  always #5 clk = ~clk;

  lru_page_replacement #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .page_number(page_number),
    .last_access(last_access),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .frame_used(frame_used),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .fault_count(fault_count)
  );

  lrupr_checker #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .page_number(page_number),
    .last_access(last_access),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .hit(hit),
    .frame_used(frame_used),
    .evicted_valid(evicted_valid),
    .evicted_page(evicted_page),
    .fault_count(fault_count),
    .errors(error_total),
    .pending(pending_results)
  );

  // Result side stalls at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic set_idle(input idle_mode_t mode);
    unique case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct  = 10;
        recv_stall_pct = 52;
      end
      IDLE_RECV_LIGHT: begin
        send_idle_pct  = 52;
        recv_stall_pct = 10;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // One access beat, with random idle cycles ahead of it.
  task automatic send_access(input logic [lrupr_pkg::PAGE_W-1:0] page, input logic seq_end);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      page_number <= lrupr_pkg::PAGE_W'($urandom);
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    page_number <= page;
    last_access <= seq_end;
    do @(posedge clk); while (in_stall);
    accesses_sent++;
  endtask

  // Let every outstanding result beat drain before touching the register.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_results != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frames(input logic [lrupr_pkg::CFG_W-1:0] count);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // A working-set sequence: pages near a random base, usually closed by a last beat.
  task automatic run_sequence();
    int                           len;
    int                           pool;
    logic [lrupr_pkg::PAGE_W-1:0] base;
    logic                         closes;
    len    = $urandom_range(3, 40);
    pool   = $urandom_range(1, 20);
    base   = lrupr_pkg::PAGE_W'($urandom);
    closes = ($urandom_range(99) < 85);
    for (int k = 0; k < len; k++)
      send_access(base ^ lrupr_pkg::PAGE_W'($urandom_range(pool - 1)),
                  closes && (k == len - 1));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(1, 6))
      send_access(lrupr_pkg::PAGE_W'($urandom), $urandom_range(3) == 0);
  endtask

  initial begin
    int phase_start;
    set_idle(IDLE_SEND_LIGHT);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset frame count: extreme pages, two hits, end of sequence, then a fresh access.
    send_access(16'h0000, 1'b0);
    send_access(16'hFFFF, 1'b0);
    send_access(16'h0000, 1'b0);
    send_access(16'h8000, 1'b0);
    send_access(16'h7FFF, 1'b0);
    send_access(16'hFFFF, 1'b1);
    send_access(16'h0000, 1'b0);

    // Three frames with page 0 left from before: fill, evict page 0, hit, then replace the oldest twice.
    set_frames(5'd3);
    send_access(16'h0001, 1'b0);
    send_access(16'h0002, 1'b0);
    send_access(16'h0003, 1'b0);
    send_access(16'h0001, 1'b0);
    send_access(16'h0004, 1'b0);
    send_access(16'h0002, 1'b1);

    // A zero frame count behaves as one frame.
    set_frames(5'd0);
    send_access(16'h0005, 1'b0);
    send_access(16'h0005, 1'b0);
    send_access(16'h0006, 1'b1);

    // Shrinking the count mid-sequence hides upper frames without losing them.
    set_frames(5'd4);
    send_access(16'h0010, 1'b0);
    send_access(16'h0011, 1'b0);
    send_access(16'h0012, 1'b0);
    send_access(16'h0013, 1'b0);
    set_frames(5'd2);
    send_access(16'h0012, 1'b0);
    set_frames(5'd4);
    send_access(16'h0013, 1'b1);

    // Counts above the maximum saturate.
    set_frames(5'd31);
    send_access(16'hAAAA, 1'b1);

    // Random phases: each sets a frame count, some leave a sequence open across it.
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idle(idle_mode_t'(p * 3 / NUM_PHASES));
      set_frames(frame_plan[p]);
      phase_start = accesses_sent;
      while (accesses_sent < phase_start + PHASE_ITEMS) begin
        if ($urandom_range(99) < 80) run_sequence();
        else run_noise();
      end
    end

    // Drain, allow for the block's latency, then give the verdict.
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_total == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
